// ----- hdl/ouvn_pkg.sv -----
// types and constants shared by the unit vector normalizer
package ouvn_pkg;

  // one root bit per stage, 64-bit radicand gives 32 root bits
  localparam int SQRT_STEPS = 32;
  // quotient never exceeds 2^30, so 31 quotient bits
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] lambda_major;
    logic signed [31:0] lambda_minor;
    logic               has_ref;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic signed [31:0] lambda_major_out;
    logic signed [31:0] lambda_minor_out;
  } result_t;

endpackage

// ----- hdl/ouvn_isqrt.sv -----
// pipelined integer square root, one root bit per stage
module ouvn_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] t,
  output logic        out_valid,
  output logic [31:0] root
);

  localparam int N = ouvn_pkg::SQRT_STEPS;

  logic [N-1:0] vld;
  logic [63:0]  tt       [N];
  logic [31:0]  rem      [N];
  logic [31:0]  rt       [N];
  logic [63:0]  tt_next  [N];
  logic [31:0]  rem_next [N];
  logic [31:0]  rt_next  [N];

  always_comb begin : comb_steps
    logic [63:0] t_in;
    logic [31:0] rm_in;
    logic [31:0] rt_in;
    logic [33:0] acc;
    logic [33:0] trial;
    logic [33:0] diff;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        t_in  = t;
        rm_in = '0;
        rt_in = '0;
      end else begin
        t_in  = tt[k-1];
        rm_in = rem[k-1];
        rt_in = rt[k-1];
      end
      acc   = {rm_in, t_in[63:62]};
      trial = {rt_in, 2'b01};
      diff  = acc - trial;
      if (acc >= trial) begin
        rem_next[k] = diff[31:0];
        rt_next[k]  = {rt_in[30:0], 1'b1};
      end else begin
        rem_next[k] = acc[31:0];
        rt_next[k]  = {rt_in[30:0], 1'b0};
      end
      tt_next[k] = {t_in[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-2:0], in_valid};
    end
    for (int k = 0; k < N; k++) begin
      tt[k]  <= tt_next[k];
      rem[k] <= rem_next[k];
      rt[k]  <= rt_next[k];
    end
  end

  assign out_valid = vld[N-1];
  assign root      = rt[N-1];

endmodule

// ----- hdl/ouvn_div.sv -----
// pipelined restoring divider, three lanes sharing one divisor
module ouvn_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0][62:0] num,
  input  logic [31:0]      den,
  output logic             out_valid,
  output logic [2:0][30:0] quo
);

  localparam int N = ouvn_pkg::DIV_STEPS;

  logic [N-1:0]     vld;
  logic [31:0]      dd      [N];
  logic [2:0][31:0] rem     [N];
  logic [2:0][30:0] nn      [N];
  logic [2:0][30:0] qq      [N];
  logic [31:0]      dd_next [N];
  logic [2:0][31:0] rem_next[N];
  logic [2:0][30:0] nn_next [N];
  logic [2:0][30:0] qq_next [N];

  always_comb begin : comb_steps
    logic [31:0]      d_in;
    logic [2:0][31:0] rm_in;
    logic [2:0][30:0] nn_in;
    logic [2:0][30:0] qq_in;
    logic [32:0]      sh;
    logic [32:0]      diff;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        d_in = den;
        for (int l = 0; l < 3; l++) begin
          rm_in[l] = num[l][62:31];
          nn_in[l] = num[l][30:0];
          qq_in[l] = '0;
        end
      end else begin
        d_in  = dd[k-1];
        rm_in = rem[k-1];
        nn_in = nn[k-1];
        qq_in = qq[k-1];
      end
      dd_next[k] = d_in;
      for (int l = 0; l < 3; l++) begin
        sh   = {rm_in[l], nn_in[l][30]};
        diff = sh - {1'b0, d_in};
        if (sh >= {1'b0, d_in}) begin
          rem_next[k][l] = diff[31:0];
          qq_next[k][l]  = {qq_in[l][29:0], 1'b1};
        end else begin
          rem_next[k][l] = sh[31:0];
          qq_next[k][l]  = {qq_in[l][29:0], 1'b0};
        end
        nn_next[k][l] = {nn_in[l][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-2:0], in_valid};
    end
    for (int k = 0; k < N; k++) begin
      dd[k]  <= dd_next[k];
      rem[k] <= rem_next[k];
      nn[k]  <= nn_next[k];
      qq[k]  <= qq_next[k];
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = qq[N-1];

endmodule

// ----- hdl/oriented_unit_vector_normalizer_top.sv -----
// top level of the oriented unit vector normalizer
// Takes one word per cycle whenever start is high; busy never rises, so a
// word can be issued every cycle. Each word comes back on result, marked by
// done for one cycle, in issue order, through the 32-stage square root pipe
// and the 31-stage divider pipe, plus nine stages for squaring, summing,
// normalizing, rounding the sign and the orientation test. The receiver
// cannot stall.
module oriented_unit_vector_normalizer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ouvn_pkg::item_t  item,
  output logic             done,
  output ouvn_pkg::result_t result
);

  localparam int LATENCY = 5 + ouvn_pkg::SQRT_STEPS + 1 + ouvn_pkg::DIV_STEPS + 3;

  typedef struct packed {
    logic [2:0][31:0]   mag;
    logic [2:0]         neg;
    logic [4:0]         e;
    logic signed [31:0] lambda_major;
    logic signed [31:0] lambda_minor;
    logic               has_ref;
    logic [2:0][31:0]   refv;
  } side_t;

  function automatic logic [4:0] lz16(input logic [15:0] x);
    logic [4:0] n;
    logic       hit;
    n   = 5'd16;
    hit = 1'b0;
    for (int b = 15; b >= 0; b--) begin
      if (!hit && x[b]) begin
        n   = 5'(15 - b);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: magnitudes
  logic  s1_vld;
  side_t s1_side;
  side_t s1_side_next;

  always_comb begin
    logic [2:0][31:0] v;
    v[0] = item.vec_x;
    v[1] = item.vec_y;
    v[2] = item.vec_z;
    for (int i = 0; i < 3; i++) begin
      s1_side_next.neg[i] = v[i][31];
      s1_side_next.mag[i] = v[i][31] ? (~v[i] + 32'd1) : v[i];
    end
    s1_side_next.e            = '0;
    s1_side_next.lambda_major = item.lambda_major;
    s1_side_next.lambda_minor = item.lambda_minor;
    s1_side_next.has_ref      = item.has_ref;
    s1_side_next.refv[0]      = item.ref_x;
    s1_side_next.refv[1]      = item.ref_y;
    s1_side_next.refv[2]      = item.ref_z;
  end

  // stages 2..5: squares, sum, leading zeros, normalize
  logic             s2_vld, s3_vld, s4_vld, s5_vld;
  side_t            s2_side, s3_side, s4_side, s5_side;
  side_t            s5_side_next;
  logic [2:0][63:0] s2_sq;
  logic [63:0]      s3_sum;
  logic [63:0]      s4_sum;
  logic [3:0][4:0]  s4_lz;
  logic [63:0]      s5_t;
  logic [5:0]       lz_all;
  logic [4:0]       e_next;

  always_comb begin
    if (s4_lz[3] != 5'd16) begin
      lz_all = {1'b0, s4_lz[3]};
    end else if (s4_lz[2] != 5'd16) begin
      lz_all = 6'd16 + {1'b0, s4_lz[2]};
    end else if (s4_lz[1] != 5'd16) begin
      lz_all = 6'd32 + {1'b0, s4_lz[1]};
    end else begin
      lz_all = 6'd48 + {1'b0, s4_lz[0]};
    end
    e_next         = lz_all[5:1];
    s5_side_next   = s4_side;
    s5_side_next.e = e_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
    s1_side <= s1_side_next;
    for (int i = 0; i < 3; i++) begin
      s2_sq[i] <= s1_side.mag[i] * s1_side.mag[i];
    end
    s2_side <= s1_side;
    // one extra unit keeps a zero vector off zero
    s3_sum  <= s2_sq[0] + s2_sq[1] + s2_sq[2] + 64'd1;
    s3_side <= s2_side;
    s4_sum  <= s3_sum;
    for (int q = 0; q < 4; q++) begin
      s4_lz[q] <= lz16(s3_sum[q*16 +: 16]);
    end
    s4_side    <= s3_side;
    s5_t       <= s4_sum << {e_next, 1'b0};
    s5_side    <= s5_side_next;
  end

  // square root pipe with side data alongside
  logic        rt_vld;
  logic [31:0] rt_root;
  side_t       sq_side [ouvn_pkg::SQRT_STEPS];

  ouvn_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .t         (s5_t),
    .out_valid (rt_vld),
    .root      (rt_root)
  );

  always_ff @(posedge clk) begin
    sq_side[0] <= s5_side;
    for (int k = 1; k < ouvn_pkg::SQRT_STEPS; k++) begin
      sq_side[k] <= sq_side[k-1];
    end
  end

  // stage 6: scaled numerators with half-divisor rounding
  logic             s6_vld;
  logic [31:0]      s6_den;
  logic [2:0][62:0] s6_num;
  side_t            s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= rt_vld;
    end
    s6_den  <= rt_root;
    s6_side <= sq_side[ouvn_pkg::SQRT_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      // scaled magnitude never exceeds the root, so 32 bits hold it
      s6_num[i] <= {1'b0, 32'(sq_side[ouvn_pkg::SQRT_STEPS-1].mag[i]
                              << sq_side[ouvn_pkg::SQRT_STEPS-1].e), 30'b0}
                   + 63'(rt_root[31:1]);
    end
  end

  // divider pipe
  logic             dv_vld;
  logic [2:0][30:0] dv_quo;
  side_t            dv_side [ouvn_pkg::DIV_STEPS];

  ouvn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_vld),
    .num       (s6_num),
    .den       (s6_den),
    .out_valid (dv_vld),
    .quo       (dv_quo)
  );

  always_ff @(posedge clk) begin
    dv_side[0] <= s6_side;
    for (int k = 1; k < ouvn_pkg::DIV_STEPS; k++) begin
      dv_side[k] <= dv_side[k-1];
    end
  end

  // stages 7..9: sign, orientation products, flip
  logic                      s7_vld, s8_vld;
  logic signed [2:0][31:0]   s7_u;
  side_t                     s7_side;
  logic signed [2:0][31:0]   s8_u;
  logic signed [2:0][63:0]   s8_prod;
  logic signed [31:0]        s8_lmaj, s8_lmin;
  logic                      s8_has_ref;
  logic signed [63:0]        dot;
  logic                      flip;

  assign dot  = s8_prod[0] + s8_prod[1] + s8_prod[2];
  assign flip = s8_has_ref && dot[63];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s7_vld <= dv_vld;
      s8_vld <= s7_vld;
      done   <= s8_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s7_u[i] <= dv_side[ouvn_pkg::DIV_STEPS-1].neg[i] ? -{1'b0, dv_quo[i]}
                                                       : {1'b0, dv_quo[i]};
    end
    s7_side <= dv_side[ouvn_pkg::DIV_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      s8_prod[i] <= $signed(s7_u[i]) * $signed(s7_side.refv[i]);
    end
    s8_u       <= s7_u;
    s8_lmaj    <= s7_side.lambda_major;
    s8_lmin    <= s7_side.lambda_minor;
    s8_has_ref <= s7_side.has_ref;
    result.unit_x           <= flip ? -s8_u[0] : s8_u[0];
    result.unit_y           <= flip ? -s8_u[1] : s8_u[1];
    result.unit_z           <= flip ? -s8_u[2] : s8_u[2];
    result.lambda_major_out <= s8_lmaj;
    result.lambda_minor_out <= s8_lmin;
  end

  // every accepted word comes out on done after passing the whole pipe
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("word did not emerge after pipeline latency");

  // normalized root lies in [2^31, 2^32)
  a_root_norm : assert property (@(posedge clk) disable iff (rst)
    s6_vld |-> s6_den[31])
    else $error("square root not normalized");

  // unit components stay within one in magnitude
  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.unit_x <= 32'sd1073741824 && result.unit_x >= -32'sd1073741824 &&
              result.unit_y <= 32'sd1073741824 && result.unit_y >= -32'sd1073741824 &&
              result.unit_z <= 32'sd1073741824 && result.unit_z >= -32'sd1073741824))
    else $error("unit component out of range");

endmodule

// ----- tb/tb.sv -----
// testbench for the oriented unit vector normalizer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 72;
  localparam int N_RANDOM = 1930;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ouvn_pkg::item_t item = '0;
  logic done;
  ouvn_pkg::result_t result;

  int unsigned send_idle_pct = 29;
  longint cycles = 0;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int flips = 0;

  ouvn_pkg::result_t expected_units[$];

  oriented_unit_vector_normalizer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // exact integer square root of a 64-bit radicand
  function automatic logic [63:0] root64(input logic [63:0] t);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > t) b = b >> 2;
    while (b != 0) begin
      if (t >= res + b) begin
        t = t - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic ouvn_pkg::result_t normalize(input ouvn_pkg::item_t w);
    logic signed [63:0] v[3];
    logic signed [63:0] rf[3];
    logic signed [63:0] u[3];
    logic [63:0] s, t, r, m, a;
    logic [127:0] q;
    logic signed [63:0] d;
    int e;
    ouvn_pkg::result_t res;
    v[0] = w.vec_x; v[1] = w.vec_y; v[2] = w.vec_z;
    rf[0] = w.ref_x; rf[1] = w.ref_y; rf[2] = w.ref_z;
    s = 1;
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      s = s + m * m;
    end
    t = s;
    e = 0;
    while (t < (64'd1 << 62) && e < 31) begin
      t = t << 2;
      e++;
    end
    r = root64(t);
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0 ? -v[i] : v[i]) << e;
      q = ((128'(a) << 30) + 128'(r >> 1)) / 128'(r);
      u[i] = v[i] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    end
    if (w.has_ref) begin
      d = u[0] * rf[0] + u[1] * rf[1] + u[2] * rf[2];
      if (d < 0) begin
        for (int i = 0; i < 3; i++) u[i] = -u[i];
      end
    end
    res.unit_x = u[0][31:0];
    res.unit_y = u[1][31:0];
    res.unit_z = u[2][31:0];
    res.lambda_major_out = w.lambda_major;
    res.lambda_minor_out = w.lambda_minor;
    return res;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return $signed($urandom_range(0, 16)) - 8;
      2: return $signed($urandom_range(0, 32'h3_ffff)) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // drive one word and wait for acceptance
  task automatic issue(input ouvn_pkg::item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    item <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_units.push_back(normalize(w));
    if (w.has_ref && normalize(w) != normalize('{w.vec_x, w.vec_y, w.vec_z,
        w.lambda_major, w.lambda_minor, 1'b0, 32'd0, 32'd0, 32'd0}))
      flips++;
    words_in++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_units.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        ouvn_pkg::result_t x;
        x = expected_units.pop_front();
        words_out++;
        if (result.unit_x !== x.unit_x) begin
          $error("unit_x expected %0d actual %0d", x.unit_x, result.unit_x);
          errors++;
        end
        if (result.unit_y !== x.unit_y) begin
          $error("unit_y expected %0d actual %0d", x.unit_y, result.unit_y);
          errors++;
        end
        if (result.unit_z !== x.unit_z) begin
          $error("unit_z expected %0d actual %0d", x.unit_z, result.unit_z);
          errors++;
        end
        if (result.lambda_major_out !== x.lambda_major_out) begin
          $error("lambda_major_out expected %0d actual %0d",
                 x.lambda_major_out, result.lambda_major_out);
          errors++;
        end
        if (result.lambda_minor_out !== x.lambda_minor_out) begin
          $error("lambda_minor_out expected %0d actual %0d",
                 x.lambda_minor_out, result.lambda_minor_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  typedef struct {
    ouvn_pkg::item_t w;
    logic check_typed;
    ouvn_pkg::result_t want;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    ouvn_pkg::item_t w;
    // zero vector, axis vectors, extremes, ref cases
    directed.push_back('{'{0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 5, 5, 5}, 1'b1,
                         '{0, 0, 0, 32'h7fff_ffff, 32'h8000_0000}});
    directed.push_back('{'{32'h10000, 0, 0, 0, 0, 1'b0, 0, 0, 0}, 1'b1,
                         '{32'h4000_0000, 0, 0, 0, 0}});
    directed.push_back('{'{0, 32'h10000, 0, 1, -1, 1'b1, 0, -1, 0}, 1'b1,
                         '{0, 32'hc000_0000, 0, 1, -1}});
    directed.push_back('{'{0, 0, 32'h8000_0000, 0, 0, 1'b0, 0, 0, 0}, 1'b1,
                         '{0, 0, 32'hc000_0000, 0, 0}});
    directed.push_back('{'{0, 0, 32'h8000_0000, 0, 0, 1'b1, 0, 0, 32'h8000_0000}, 1'b1,
                         '{0, 0, 32'hc000_0000, 0, 0}});
    directed.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1'b1,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
    directed.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b1,
                           32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0});
    // zero dot product (perpendicular reference, no flip), then other ref cases
    directed.push_back('{'{1, 0, 0, 0, 0, 1'b1, 0, 7, -7}, 1'b0, '0});
    directed.push_back('{'{1, 1, 0, 0, 0, 1'b1, 3, -3, 9}, 1'b0, '0});
    directed.push_back('{'{1, -1, 1, 0, 0, 1'b1, -1, -1, -1}, 1'b0, '0});
    directed.push_back('{'{-1, 0, 0, 0, 0, 1'b0, 1, 1, 1}, 1'b0, '0});
    directed.push_back('{'{3, 4, 0, 0, 0, 1'b1, -1, 0, 0}, 1'b0, '0});
    directed.push_back('{'{32'h7fff_ffff, 1, 32'h8000_0000, 0, 0, 1'b1, 1, 0, 1}, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].check_typed && normalize(directed[i].w) != directed[i].want) begin
        $error("typed row %0d disagrees with predictor", i);
        errors++;
      end
      issue(directed[i].w);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) send_idle_pct = 83;
      if (n == 2 * N_RANDOM / 3) send_idle_pct = 0;
      w.vec_x = rand_comp();
      w.vec_y = rand_comp();
      w.vec_z = rand_comp();
      w.lambda_major = $urandom;
      w.lambda_minor = $urandom;
      w.has_ref = $urandom_range(0, 3) != 0;
      w.ref_x = rand_comp();
      w.ref_y = rand_comp();
      w.ref_z = rand_comp();
      issue(w);
    end
    start <= 1'b0;

    while (expected_units.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("%0d words issued, %0d results checked, %0d flipped by reference",
             words_in, words_out, flips);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
